// ----- rtl/lwl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwl_pkg
// Shared sizes, operation and error codes, sequencer states and memory
// request types for the literal watch list table.
// ----------------------------------------------------------------------------
package lwl_pkg;

  // Table dimensions.
  localparam int MAX_VARIABLES      = 256;
  localparam int LIST_DEPTH         = 16;
  localparam int CONSTRAINT_ID_BITS = 16;

  localparam int NUM_LISTS = 2 * MAX_VARIABLES;
  localparam int LIST_W    = $clog2(NUM_LISTS);
  localparam int POS_W     = $clog2(LIST_DEPTH);
  localparam int LEN_W     = $clog2(LIST_DEPTH + 1);
  localparam int ENT_AW    = LIST_W + POS_W;
  localparam int WEIGHT_W  = 32;
  localparam int ENT_W     = CONSTRAINT_ID_BITS + WEIGHT_W;

  // Fixed widths of the word fields.
  localparam int OP_W   = 3;
  localparam int VAR_W  = 8;
  localparam int CID_W  = 16;
  localparam int POSF_W = 4;
  localparam int LENF_W = 5;
  localparam int ERR_W  = 2;
  localparam int CFG_W  = 9;

  localparam logic [CFG_W-1:0] VARS_RESET = CFG_W'(256);

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [ERR_W-1:0] err_t;

  // Operation codes.
  localparam op_t OP_ADD        = 3'd0;
  localparam op_t OP_REMOVE_ID  = 3'd1;
  localparam op_t OP_REMOVE_POS = 3'd2;
  localparam op_t OP_CLEAR      = 3'd3;
  localparam op_t OP_QUERY      = 3'd4;
  localparam op_t OP_READ       = 3'd5;

  // Error codes.
  localparam err_t ERR_OK    = 2'd0;
  localparam err_t ERR_RANGE = 2'd1;
  localparam err_t ERR_FULL  = 2'd2;
  localparam err_t ERR_POS   = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEN,
    ST_SCAN,
    ST_MOVE,
    ST_READ,
    ST_RESP
  } state_t;

  // Request to the length memory.
  typedef struct packed {
    logic              we;
    logic [LIST_W-1:0] waddr;
    logic [LEN_W-1:0]  wdata;
    logic              re;
    logic [LIST_W-1:0] raddr;
  } len_req_t;

  // Request to the entry memory.
  typedef struct packed {
    logic              we;
    logic [ENT_AW-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic              re;
    logic [ENT_AW-1:0] raddr;
  } ent_req_t;

endpackage

// ----- rtl/lwl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwl_if
// Valid/ready channels of the literal watch list table: operation words,
// result words and configuration writes.
// ----------------------------------------------------------------------------

// Operation word channel.
interface lwl_in_if;
  logic                         valid;
  logic                         ready;
  logic [lwl_pkg::OP_W-1:0]     operation;
  logic [lwl_pkg::VAR_W-1:0]    variable;
  logic                         negative;
  logic [lwl_pkg::CID_W-1:0]    constraint_id;
  logic signed [31:0]           weight;
  logic [lwl_pkg::POSF_W-1:0]   position;

  modport source (output valid, operation, variable, negative, constraint_id, weight,
                  position, input ready);
  modport sink (input valid, operation, variable, negative, constraint_id, weight,
                position, output ready);
endinterface

// Result word channel.
interface lwl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [lwl_pkg::ERR_W-1:0]    error;
  logic [lwl_pkg::LENF_W-1:0]   length;
  logic [lwl_pkg::CID_W-1:0]    out_constraint_id;
  logic signed [31:0]           out_weight;
  logic [lwl_pkg::POSF_W-1:0]   match_position;

  modport source (output valid, found, error, length, out_constraint_id, out_weight,
                  match_position, input ready);
  modport sink (input valid, found, error, length, out_constraint_id, out_weight,
                match_position, output ready);
endinterface

// Configuration write channel.
interface lwl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lwl_pkg::CFG_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/lwl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwl_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lwl_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lwl_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwl_seq
// Operation sequencer: reads the list length, scans or reads entries one
// per cycle, writes back entries and lengths, and holds the result word.
// ----------------------------------------------------------------------------
module lwl_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  lwl_in_if.sink                            in_word,
  lwl_out_if.source                         out_word,
  lwl_cfg_if.sink                           cfg_word,
  output lwl_pkg::len_req_t                 len_req,
  input  logic [lwl_pkg::LEN_W-1:0]         len_rdata,
  output lwl_pkg::ent_req_t                 ent_req,
  input  logic [lwl_pkg::ENT_W-1:0]         ent_rdata
);

  import lwl_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]              vars_r;
  logic [LIST_W-1:0]             clr_r;

  // Latched operation word.
  op_t                           op_r;
  logic [LIST_W-1:0]             li_r;
  logic [CONSTRAINT_ID_BITS-1:0] id_r;
  logic [WEIGHT_W-1:0]           weight_r;
  logic [POSF_W-1:0]             pos_r;

  logic [LEN_W-1:0]              len_r;
  logic [POS_W-1:0]              idx_r;

  // Pending result.
  logic                          res_found_r;
  err_t                          res_err_r;
  logic [LEN_W-1:0]              res_len_r;
  logic [CID_W-1:0]              res_cid_r;
  logic [WEIGHT_W-1:0]           res_w_r;
  logic [POS_W-1:0]              res_mpos_r;

  // Output register.
  logic                          out_valid_r;
  logic                          out_found_r;
  err_t                          out_err_r;
  logic [LENF_W-1:0]             out_len_r;
  logic [CID_W-1:0]              out_cid_r;
  logic [WEIGHT_W-1:0]           out_w_r;
  logic [POSF_W-1:0]             out_mpos_r;

  logic                          in_fire;
  logic [31:0]                   limit;
  logic                          out_of_range;
  logic [LIST_W-1:0]             in_li;
  logic                          full;
  logic                          pos_bad;
  logic [POS_W-1:0]              fetched_last;
  logic [POS_W-1:0]              scan_last;
  logic                          scan_at_last;
  logic                          hit;
  logic                          is_remove;
  logic                          resp_load;

  // Handshake and decode of the incoming word.
  assign in_word.ready = (state_r == ST_IDLE);
  assign cfg_word.ready = 1'b1;
  assign in_fire = in_word.valid && in_word.ready;

  assign limit = (32'(vars_r) > 32'(MAX_VARIABLES)) ? 32'(MAX_VARIABLES) : 32'(vars_r);
  assign out_of_range = 32'(in_word.variable) >= limit;
  assign in_li = LIST_W'({in_word.variable, in_word.negative});

  // Checks on the length just read.
  assign full = 32'(len_rdata) >= 32'(LIST_DEPTH);
  assign pos_bad = (32'(pos_r) >= 32'(len_rdata)) || (32'(pos_r) >= 32'(LIST_DEPTH));
  assign fetched_last = POS_W'(len_rdata - 1'b1);

  // Scan compare on the entry just read.
  assign scan_last = POS_W'(len_r - 1'b1);
  assign scan_at_last = (idx_r == scan_last);
  assign hit = (ent_rdata[ENT_W-1 -: CONSTRAINT_ID_BITS] == id_r);
  assign is_remove = (op_r == OP_REMOVE_ID);

  assign resp_load = (state_r == ST_RESP) && (!out_valid_r || out_word.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (32'(clr_r) == NUM_LISTS - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = out_of_range ? ST_RESP : ST_LEN;
      end
      ST_LEN: begin
        case (op_r)
          OP_REMOVE_ID, OP_QUERY: begin
            state_nxt = (len_rdata == '0) ? ST_RESP : ST_SCAN;
          end
          OP_REMOVE_POS: begin
            state_nxt = pos_bad ? ST_RESP : ST_MOVE;
          end
          OP_READ: begin
            state_nxt = pos_bad ? ST_RESP : ST_READ;
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = (is_remove && !scan_at_last) ? ST_MOVE : ST_RESP;
        end else if (scan_at_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_MOVE: state_nxt = ST_RESP;
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: begin
        if (resp_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory requests.
  always_comb begin
    len_req = '0;
    ent_req = '0;
    case (state_r)
      ST_CLEAR: begin
        len_req.we    = 1'b1;
        len_req.waddr = clr_r;
        len_req.wdata = '0;
      end
      ST_IDLE: begin
        len_req.re    = in_fire;
        len_req.raddr = in_li;
      end
      ST_LEN: begin
        len_req.waddr = li_r;
        case (op_r)
          OP_ADD: begin
            len_req.we    = !full;
            len_req.wdata = LEN_W'(len_rdata + 1'b1);
            ent_req.we    = !full;
            ent_req.waddr = {li_r, POS_W'(len_rdata)};
            ent_req.wdata = {id_r, weight_r};
          end
          OP_CLEAR: begin
            len_req.we    = 1'b1;
            len_req.wdata = '0;
          end
          OP_REMOVE_ID, OP_QUERY: begin
            ent_req.re    = (len_rdata != '0);
            ent_req.raddr = {li_r, POS_W'(0)};
          end
          OP_REMOVE_POS: begin
            ent_req.re    = !pos_bad;
            ent_req.raddr = {li_r, fetched_last};
          end
          OP_READ: begin
            ent_req.re    = !pos_bad;
            ent_req.raddr = {li_r, POS_W'(pos_r)};
          end
          default: begin
            len_req.we = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        len_req.waddr = li_r;
        len_req.wdata = LEN_W'(len_r - 1'b1);
        if (hit) begin
          // A remove that matches the last entry shortens the list without a move.
          len_req.we    = is_remove && scan_at_last;
          ent_req.re    = is_remove && !scan_at_last;
          ent_req.raddr = {li_r, scan_last};
        end else begin
          ent_req.re    = !scan_at_last;
          ent_req.raddr = {li_r, POS_W'(idx_r + 1'b1)};
        end
      end
      ST_MOVE: begin
        // The last entry fills the hole.
        len_req.we    = 1'b1;
        len_req.waddr = li_r;
        len_req.wdata = LEN_W'(len_r - 1'b1);
        ent_req.we    = 1'b1;
        ent_req.waddr = {li_r, idx_r};
        ent_req.wdata = ent_rdata;
      end
      default: begin
        len_req.we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      vars_r      <= VARS_RESET;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_word.valid && cfg_word.ready) vars_r <= cfg_word.data;
      if (state_r == ST_CLEAR) clr_r <= LIST_W'(clr_r + 1'b1);
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operation word, scan index and result registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_r        <= in_word.operation;
          li_r        <= in_li;
          id_r        <= CONSTRAINT_ID_BITS'(in_word.constraint_id);
          weight_r    <= in_word.weight;
          pos_r       <= in_word.position;
          res_found_r <= 1'b0;
          res_err_r   <= ERR_RANGE;
          res_len_r   <= '0;
          res_cid_r   <= '0;
          res_w_r     <= '0;
          res_mpos_r  <= '0;
        end
      end
      ST_LEN: begin
        len_r       <= len_rdata;
        idx_r       <= '0;
        res_err_r   <= ERR_OK;
        res_len_r   <= len_rdata;
        case (op_r)
          OP_ADD: begin
            if (full) begin
              res_err_r <= ERR_FULL;
            end else begin
              res_len_r <= LEN_W'(len_rdata + 1'b1);
            end
          end
          OP_CLEAR: begin
            res_len_r <= '0;
          end
          OP_REMOVE_POS: begin
            idx_r <= POS_W'(pos_r);
            if (pos_bad) begin
              res_err_r <= ERR_POS;
            end else begin
              res_len_r <= LEN_W'(len_rdata - 1'b1);
            end
          end
          OP_READ: begin
            if (pos_bad) res_err_r <= ERR_POS;
          end
          default: begin
            res_err_r <= ERR_OK;
          end
        endcase
      end
      ST_SCAN: begin
        if (hit) begin
          res_found_r <= 1'b1;
          res_mpos_r  <= idx_r;
          if (is_remove) res_len_r <= LEN_W'(len_r - 1'b1);
        end else begin
          idx_r <= POS_W'(idx_r + 1'b1);
        end
      end
      ST_READ: begin
        res_cid_r <= CID_W'(ent_rdata[ENT_W-1 -: CONSTRAINT_ID_BITS]);
        res_w_r   <= ent_rdata[WEIGHT_W-1:0];
      end
      default: begin
        res_mpos_r <= res_mpos_r;
      end
    endcase
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_found_r <= res_found_r;
      out_err_r   <= res_err_r;
      out_len_r   <= LENF_W'(res_len_r);
      out_cid_r   <= res_cid_r;
      out_w_r     <= res_w_r;
      out_mpos_r  <= POSF_W'(res_mpos_r);
    end
  end

  assign out_word.valid             = out_valid_r;
  assign out_word.found             = out_found_r;
  assign out_word.error             = out_err_r;
  assign out_word.length            = out_len_r;
  assign out_word.out_constraint_id = out_cid_r;
  assign out_word.out_weight        = out_w_r;
  assign out_word.match_position    = out_mpos_r;

endmodule

// ----- rtl/literal_watch_list_table.sv -----
`timescale 1ns / 1ps
// Sequence: a word whose literal is out of range goes straight to the result; add, clear,
// read and remove at position first read the list length; query and remove by constraint
// then scan the list, which reads one entry per cycle.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset: synchronous, active low; afterwards all NUM_LISTS (512) list lengths are
// cleared, during which no word is taken. Configuration is always taken.
// ----------------------------------------------------------------------------
// literal_watch_list_table
// Per-literal bounded watcher lists of (constraint id, weight) pairs held in
// a length memory and an entry memory, driven by one operation sequencer.
// ----------------------------------------------------------------------------
module literal_watch_list_table (
  input  logic       clk,
  input  logic       rst_n,
  lwl_in_if.sink     in_word,
  lwl_out_if.source  out_word,
  lwl_cfg_if.sink    cfg_word
);

  import lwl_pkg::*;

  len_req_t          len_req;
  ent_req_t          ent_req;
  logic [LEN_W-1:0]  len_rdata;
  logic [ENT_W-1:0]  ent_rdata;

  // Sequencer.
  lwl_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_word  (cfg_word),
    .len_req   (len_req),
    .len_rdata (len_rdata),
    .ent_req   (ent_req),
    .ent_rdata (ent_rdata)
  );

  // One length per literal.
  lwl_ram #(
    .WIDTH  (LEN_W),
    .ADDR_W (LIST_W)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_req.we),
    .waddr (len_req.waddr),
    .wdata (len_req.wdata),
    .re    (len_req.re),
    .raddr (len_req.raddr),
    .rdata (len_rdata)
  );

  // Watcher entries, LIST_DEPTH slots per literal.
  lwl_ram #(
    .WIDTH  (ENT_W),
    .ADDR_W (ENT_AW)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_req.we),
    .waddr (ent_req.waddr),
    .wdata (ent_req.wdata),
    .re    (ent_req.re),
    .raddr (ent_req.raddr),
    .rdata (ent_rdata)
  );

endmodule

// ----- rtl/lwl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwl_checker
// Port-level checks of the result channel of the literal watch list table.
// ----------------------------------------------------------------------------
module lwl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [lwl_pkg::ERR_W-1:0]   out_error,
  input logic [lwl_pkg::LENF_W-1:0]  out_length,
  input logic [lwl_pkg::CID_W-1:0]   out_cid,
  input logic [31:0]                 out_weight,
  input logic [lwl_pkg::POSF_W-1:0]  out_mpos
);

  import lwl_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_found, out_error, out_length, out_cid, out_weight, out_mpos}))
    else $error("result word changed while stalled");

  // A literal out of range reports nothing else.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error == ERR_RANGE) |-> (out_length == '0) && !out_found)
    else $error("out of range result carries a length or a match");

  // Any error clears the match and the read entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error != ERR_OK) |->
      !out_found && (out_cid == '0) && (out_weight == '0) && (out_mpos == '0))
    else $error("error result carries entry data");

  // A list never grows past its depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_length) <= 32'(LIST_DEPTH))
    else $error("list length beyond depth");

endmodule

bind literal_watch_list_table lwl_checker u_lwl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_word.valid),
  .out_ready  (out_word.ready),
  .out_found  (out_word.found),
  .out_error  (out_word.error),
  .out_length (out_word.length),
  .out_cid    (out_word.out_constraint_id),
  .out_weight (out_word.out_weight),
  .out_mpos   (out_word.match_position)
);
